// ===== sv/mcsf_pkg.sv =====
package mcsf_pkg;

    // Field widths fixed by the item formats
    localparam int OP_W      = 3;
    localparam int CHAN_IN_W = 4;
    localparam int SAMPLE_W  = 32;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 12;
    localparam int FREE_W    = 13;

    // Default sizing
    localparam int DEF_FIFO_DEPTH   = 4096;
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_MAX_BURST    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_BURST = 3'd2,
        OP_CLEAR = 3'd3,
        OP_QUERY = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_EXEC,
        S_BURST,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [CHAN_IN_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample_in;
        logic [COUNT_W-1:0]   burst_count;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                data_valid;
        logic [SAMPLE_W-1:0] sample_out;
        logic                last_of_run;
        logic [FILL_W-1:0]   fill_level;
        logic [FREE_W-1:0]   free_space;
    } t_result;

endpackage

// ===== sv/multichannel_sample_fifo_unit.sv =====
// Multichannel sample FIFO: NUM_CHANNELS circular FIFOs of FIFO_DEPTH words share
// one sample RAM; each channel keeps a write and a read pointer in a small pointer RAM.
// Command channel: drive i_item and raise start; the item is taken at an edge where
// start is high and busy is low. busy stays high until every result of the item has
// been shown.
// Result channel: each result sits on o_result for exactly one cycle, marked by
// o_strobe. The receiver cannot stall; it must take every strobed result.
// Timing: the pointer RAM is read at the accepting edge; the pointers are loaded
// (S_EVAL), evaluated (S_EXEC) and written back (S_COMMIT), then the block returns to
// idle to take the next item. Write, clear, query, a read of an empty channel, a
// zero-count burst and every failed burst give one result in the write-back cycle. A
// read one (n = 1) or a burst of n samples passes through S_BURST, which issues one
// sample RAM read per cycle; the results come in consecutive cycles up to the
// write-back cycle, the last one marked last_of_run. The single read port of the
// sample RAM sets the one-sample-per-cycle burst pace.
// Reset: pointer valid bits clear, so every channel reads as empty with both pointers
// at zero; no clearing pass is needed and an item may start right after reset.
module multichannel_sample_fifo_unit #(
    parameter int FIFO_DEPTH   = mcsf_pkg::DEF_FIFO_DEPTH,
    parameter int NUM_CHANNELS = mcsf_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_BURST    = mcsf_pkg::DEF_MAX_BURST
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mcsf_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output mcsf_pkg::t_result o_result
);

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WORDS   = NUM_CHANNELS * FIFO_DEPTH;
    localparam int SA_W    = $clog2(WORDS);
    localparam int CMP_W   = ((PTR_W > mcsf_pkg::COUNT_W) ? PTR_W : mcsf_pkg::COUNT_W) + 1;
    localparam int CH_CODES = 2 ** mcsf_pkg::CHAN_IN_W;

    // Fold the channel field onto the implemented channels (constant table)
    logic [CH_W-1:0] ch_map [CH_CODES];
    for (genvar g = 0; g < CH_CODES; g++) begin : g_chmap
        assign ch_map[g] = CH_W'(g % NUM_CHANNELS);
    end

    mcsf_pkg::t_state r_state, n_state;
    mcsf_pkg::t_item  r_item,  n_item;
    logic [CH_W-1:0]  r_ch,    n_ch;
    logic [SA_W-1:0]  r_base,  n_base;
    logic [PTR_W-1:0] r_wp,    n_wp;
    logic [PTR_W-1:0] r_rp,    n_rp;
    logic [PTR_W-1:0] r_fill,  n_fill;
    logic [mcsf_pkg::COUNT_W-1:0] r_left, n_left;
    logic             r_strobe, n_strobe;
    logic [mcsf_pkg::STATUS_W-1:0] r_status, n_status;
    logic             r_dvalid, n_dvalid;
    logic             r_last,   n_last;
    logic [NUM_CHANNELS-1:0] r_pvalid, n_pvalid;

    // Pointer RAM: {write pointer, read pointer} per channel
    logic                 ptr_we;
    logic [2*PTR_W-1:0]   ptr_rdata;
    logic [CH_W-1:0]      in_ch;

    // Sample RAM
    logic                         st_we;
    logic [SA_W-1:0]              st_waddr;
    logic [SA_W-1:0]              st_raddr;
    logic [mcsf_pkg::SAMPLE_W-1:0] st_rdata;

    // Evaluation helpers
    logic [PTR_W-1:0] ev_wp, ev_rp;
    logic [PTR_W:0]   ev_diff, ev_fill;
    logic [CMP_W-1:0] cnt_ext, fill_ext, fill_sub;
    logic             burst_short;
    logic [31:0]      fill32, free32;

    assign in_ch = ch_map[i_item.channel];

    mcsf_ram #(
        .WIDTH (2 * PTR_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_ch),
        .i_wdata ({r_wp, r_rp}),
        .i_raddr (in_ch),
        .o_rdata (ptr_rdata)
    );

    mcsf_ram #(
        .WIDTH (mcsf_pkg::SAMPLE_W),
        .DEPTH (WORDS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_item.sample_in),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign st_waddr = r_base + SA_W'(r_wp);
    assign st_raddr = r_base + SA_W'(r_rp);

    // A channel never committed reads as both pointers zero
    assign ev_wp = r_pvalid[r_ch] ? ptr_rdata[2*PTR_W-1:PTR_W] : '0;
    assign ev_rp = r_pvalid[r_ch] ? ptr_rdata[PTR_W-1:0]       : '0;
    assign ev_diff = {1'b0, ev_wp} - {1'b0, ev_rp};
    assign ev_fill = ev_diff[PTR_W] ? ev_diff + (PTR_W+1)'(FIFO_DEPTH) : ev_diff;

    assign cnt_ext     = CMP_W'(r_item.burst_count);
    assign fill_ext    = CMP_W'(r_fill);
    assign fill_sub    = fill_ext - cnt_ext;
    assign burst_short = (r_item.burst_count > mcsf_pkg::COUNT_W'(MAX_BURST))
                         || (cnt_ext > fill_ext);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_ch     = r_ch;
        n_base   = r_base;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_fill   = r_fill;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_status = r_status;
        n_dvalid = r_dvalid;
        n_last   = r_last;
        n_pvalid = r_pvalid;
        ptr_we   = 1'b0;
        st_we    = 1'b0;

        case (r_state)
            mcsf_pkg::S_IDLE: begin
                // Take the item; the pointer RAM read is already addressed by it
                if (start) begin
                    n_item  = i_item;
                    n_ch    = in_ch;
                    n_base  = SA_W'(in_ch) * SA_W'(FIFO_DEPTH);
                    n_state = mcsf_pkg::S_EVAL;
                end
            end
            mcsf_pkg::S_EVAL: begin
                n_wp    = ev_wp;
                n_rp    = ev_rp;
                n_fill  = ev_fill[PTR_W-1:0];
                n_state = mcsf_pkg::S_EXEC;
            end
            mcsf_pkg::S_EXEC: begin
                // Default: one result, status ok, no sample, then commit
                n_strobe = 1'b1;
                n_status = mcsf_pkg::ST_OK;
                n_dvalid = 1'b0;
                n_last   = 1'b1;
                n_state  = mcsf_pkg::S_COMMIT;
                case (mcsf_pkg::t_op'(r_item.operation))
                    mcsf_pkg::OP_WRITE: begin
                        if (r_fill == PTR_W'(FIFO_DEPTH - 1)) begin
                            n_status = mcsf_pkg::ST_FULL;
                        end else begin
                            st_we  = 1'b1;
                            n_wp   = advance(r_wp);
                            n_fill = r_fill + 1'b1;
                        end
                    end
                    mcsf_pkg::OP_READ: begin
                        if (r_fill == '0) begin
                            n_status = mcsf_pkg::ST_EMPTY;
                        end else begin
                            n_strobe = 1'b0;
                            n_left   = mcsf_pkg::COUNT_W'(1);
                            n_fill   = r_fill - 1'b1;
                            n_state  = mcsf_pkg::S_BURST;
                        end
                    end
                    mcsf_pkg::OP_BURST: begin
                        if (burst_short) begin
                            n_status = mcsf_pkg::ST_SHORT;
                        end else if (r_item.burst_count != '0) begin
                            n_strobe = 1'b0;
                            n_left   = r_item.burst_count;
                            n_fill   = fill_sub[PTR_W-1:0];
                            n_state  = mcsf_pkg::S_BURST;
                        end
                    end
                    mcsf_pkg::OP_CLEAR: begin
                        n_wp   = '0;
                        n_rp   = '0;
                        n_fill = '0;
                    end
                    mcsf_pkg::OP_QUERY: ;
                    default: ;
                endcase
            end
            mcsf_pkg::S_BURST: begin
                // Issue one sample read per cycle; its result shows next cycle
                n_rp     = advance(r_rp);
                n_left   = r_left - 1'b1;
                n_strobe = 1'b1;
                n_status = mcsf_pkg::ST_OK;
                n_dvalid = 1'b1;
                n_last   = (r_left == mcsf_pkg::COUNT_W'(1));
                if (r_left == mcsf_pkg::COUNT_W'(1)) begin
                    n_state = mcsf_pkg::S_COMMIT;
                end
            end
            mcsf_pkg::S_COMMIT: begin
                // Write back the pointers and mark the channel as holding them
                ptr_we         = 1'b1;
                n_pvalid[r_ch] = 1'b1;
                n_state        = mcsf_pkg::S_IDLE;
            end
            default: begin
                n_state = mcsf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mcsf_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_pvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pvalid <= n_pvalid;
        end
        r_item   <= n_item;
        r_ch     <= n_ch;
        r_base   <= n_base;
        r_wp     <= n_wp;
        r_rp     <= n_rp;
        r_fill   <= n_fill;
        r_left   <= n_left;
        r_status <= n_status;
        r_dvalid <= n_dvalid;
        r_last   <= n_last;
    end

    assign fill32 = 32'(r_fill);
    assign free32 = 32'(FIFO_DEPTH) - fill32;

    assign busy     = (r_state != mcsf_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result.status      = r_status;
    assign o_result.data_valid  = r_dvalid;
    assign o_result.sample_out  = r_dvalid ? st_rdata : '0;
    assign o_result.last_of_run = r_last;
    assign o_result.fill_level  = fill32[mcsf_pkg::FILL_W-1:0];
    assign o_result.free_space  = free32[mcsf_pkg::FREE_W-1:0];

    // Results come only out of a running item
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // The last result of an item frees the block in the next cycle
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |=> !busy)
        else $error("block still busy after last result");

    // A result that carries a sample always reports ok
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.data_valid) |-> (o_result.status == mcsf_pkg::ST_OK))
        else $error("sample result with failing status");

    // Sample RAM writes happen only while executing an item
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_we |-> (r_state == mcsf_pkg::S_EXEC))
        else $error("sample write outside execute step");

endmodule

// ===== sv/mcsf_ram.sv =====
module mcsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int DEPTH          = mcsf_pkg::DEF_FIFO_DEPTH;
    localparam int CHANNELS       = mcsf_pkg::DEF_NUM_CHANNELS;
    localparam int BURST_MAX      = mcsf_pkg::DEF_MAX_BURST;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 10;
    localparam int PHASE_ITEMS    = 27;

    // Operation codes outside the defined set; the block treats them as a query
    localparam logic [mcsf_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [mcsf_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [mcsf_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    mcsf_pkg::t_item   i_item  = '0;
    logic              busy;
    logic              o_strobe;
    mcsf_pkg::t_result o_result;

    always #5 i_clk = ~i_clk;

    multichannel_sample_fifo_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Shadow copy of the FIFO state: one sample memory, one pointer pair per channel
    logic [mcsf_pkg::SAMPLE_W-1:0] sample_mem [0:CHANNELS*DEPTH-1];
    logic [mcsf_pkg::FILL_W-1:0]   wr_ptr     [0:CHANNELS-1];
    logic [mcsf_pkg::FILL_W-1:0]   rd_ptr     [0:CHANNELS-1];

    mcsf_pkg::t_item   pending_items[$];
    mcsf_pkg::t_result expected_results[$];
    mcsf_pkg::t_result want;

    int   err_count    = 0;
    int   wait_cycles  = 0;
    int   quiet_cycles = 0;
    logic idle_on      = 1'b1;

    // Build one result; fill and free space reflect the pointers as they stand now
    function automatic mcsf_pkg::t_result make_result(
            input logic [mcsf_pkg::STATUS_W-1:0]  st,
            input logic                           valid,
            input logic [mcsf_pkg::SAMPLE_W-1:0]  smp,
            input logic                           last,
            input logic [mcsf_pkg::CHAN_IN_W-1:0] ch);
        mcsf_pkg::t_result r;
        logic [mcsf_pkg::FILL_W-1:0] fill;
        fill = wr_ptr[ch] - rd_ptr[ch];
        r.status      = st;
        r.data_valid  = valid;
        r.sample_out  = smp;
        r.last_of_run = last;
        r.fill_level  = fill;
        r.free_space  = mcsf_pkg::FREE_W'(DEPTH - fill);
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue the results it causes
    task automatic predict_fifo(input mcsf_pkg::t_item it);
        logic [mcsf_pkg::OP_W-1:0]      op;
        logic [mcsf_pkg::CHAN_IN_W-1:0] ch;
        logic [mcsf_pkg::COUNT_W-1:0]   cnt;
        logic [mcsf_pkg::FILL_W-1:0]    fill;
        logic [mcsf_pkg::SAMPLE_W-1:0]  burst_vals[$];
        logic [mcsf_pkg::SAMPLE_W-1:0]  smp;
        op   = it.operation;
        ch   = mcsf_pkg::CHAN_IN_W'(it.channel % CHANNELS);
        cnt  = it.burst_count;
        fill = wr_ptr[ch] - rd_ptr[ch];
        case (op)
            mcsf_pkg::OP_WRITE: begin
                if (wr_ptr[ch] + 1'b1 == rd_ptr[ch]) begin
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_FULL, 1'b0, '0, 1'b1, ch));
                end else begin
                    sample_mem[{ch, wr_ptr[ch]}] = it.sample_in;
                    wr_ptr[ch] = wr_ptr[ch] + 1'b1;
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_OK, 1'b0, '0, 1'b1, ch));
                end
            end
            mcsf_pkg::OP_READ: begin
                if (rd_ptr[ch] == wr_ptr[ch]) begin
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_EMPTY, 1'b0, '0, 1'b1, ch));
                end else begin
                    smp = sample_mem[{ch, rd_ptr[ch]}];
                    rd_ptr[ch] = rd_ptr[ch] + 1'b1;
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_OK, 1'b1, smp, 1'b1, ch));
                end
            end
            mcsf_pkg::OP_BURST: begin
                if (cnt > BURST_MAX || cnt > fill) begin
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_SHORT, 1'b0, '0, 1'b1, ch));
                end else if (cnt == 0) begin
                    expected_results.push_back(
                        make_result(mcsf_pkg::ST_OK, 1'b0, '0, 1'b1, ch));
                end else begin
                    // Pop everything first: every result carries the fill after the burst
                    for (int i = 0; i < cnt; i++) begin
                        burst_vals.push_back(sample_mem[{ch, rd_ptr[ch]}]);
                        rd_ptr[ch] = rd_ptr[ch] + 1'b1;
                    end
                    for (int i = 0; i < cnt; i++) begin
                        expected_results.push_back(make_result(mcsf_pkg::ST_OK, 1'b1,
                                                               burst_vals[i],
                                                               (i == cnt - 1), ch));
                    end
                end
            end
            mcsf_pkg::OP_CLEAR: begin
                wr_ptr[ch] = '0;
                rd_ptr[ch] = '0;
                expected_results.push_back(make_result(mcsf_pkg::ST_OK, 1'b0, '0, 1'b1, ch));
            end
            default: begin
                expected_results.push_back(make_result(mcsf_pkg::ST_OK, 1'b0, '0, 1'b1, ch));
            end
        endcase
    endtask

    task automatic queue_item(input logic [mcsf_pkg::OP_W-1:0] op, input logic [31:0] ch,
                              input logic [mcsf_pkg::SAMPLE_W-1:0] smp,
                              input logic [31:0] n);
        mcsf_pkg::t_item it;
        it.operation   = op;
        it.channel     = mcsf_pkg::CHAN_IN_W'(ch);
        it.sample_in   = smp;
        it.burst_count = mcsf_pkg::COUNT_W'(n);
        pending_items.push_back(it);
    endtask

    // Hold until every queued item is taken and every result has come back
    task automatic wait_drained;
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
    endtask

    task automatic check_field(input string name,
                               input logic [mcsf_pkg::SAMPLE_W-1:0] exp_val,
                               input logic [mcsf_pkg::SAMPLE_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            err_count++;
        end
    endtask

    // Driver: take the item on start && !busy, then idle for a drawn number of free cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            wait_cycles = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                predict_fifo(i_item);
                wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (wait_cycles > 0) begin
                if (!busy) wait_cycles--;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation: status %0d sample 0x%0h",
                       o_result.status, o_result.sample_out);
                err_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", mcsf_pkg::SAMPLE_W'(want.status),
                            mcsf_pkg::SAMPLE_W'(o_result.status));
                check_field("data_valid", mcsf_pkg::SAMPLE_W'(want.data_valid),
                            mcsf_pkg::SAMPLE_W'(o_result.data_valid));
                check_field("sample_out", want.sample_out, o_result.sample_out);
                check_field("last_of_run", mcsf_pkg::SAMPLE_W'(want.last_of_run),
                            mcsf_pkg::SAMPLE_W'(o_result.last_of_run));
                check_field("fill_level", mcsf_pkg::SAMPLE_W'(want.fill_level),
                            mcsf_pkg::SAMPLE_W'(o_result.fill_level));
                check_field("free_space", mcsf_pkg::SAMPLE_W'(want.free_space),
                            mcsf_pkg::SAMPLE_W'(o_result.free_space));
            end
        end
    end

    // Watchdog: end the run when neither side moves an item for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int r;
        int ch;
        int n;
        logic [mcsf_pkg::OP_W-1:0] spare_op;
        for (int c = 0; c < CHANNELS; c++) begin
            wr_ptr[c] = '0;
            rd_ptr[c] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, sample extremes, burst limits, spare opcodes, clear
        idle_on = 1'b1;
        queue_item(mcsf_pkg::OP_QUERY, 0, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_READ,  0, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, 0);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, 1);
        queue_item(mcsf_pkg::OP_WRITE, 0, 32'h0000_0000, $urandom);
        queue_item(mcsf_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, $urandom);
        queue_item(mcsf_pkg::OP_WRITE, 0, 32'hA5A5_5A5A, $urandom);
        queue_item(mcsf_pkg::OP_QUERY, 0, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, 127);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, BURST_MAX + 1);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, BURST_MAX);
        queue_item(mcsf_pkg::OP_BURST, 0, $urandom, 2);
        queue_item(mcsf_pkg::OP_READ,  0, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_READ,  0, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_WRITE, 15, 32'h5A5A_A5A5, $urandom);
        queue_item(mcsf_pkg::OP_WRITE, 15, $urandom, $urandom);
        queue_item(OP_SPARE5, 15, $urandom, $urandom);
        queue_item(OP_SPARE6, 15, $urandom, $urandom);
        queue_item(OP_SPARE7, 15, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_CLEAR, 15, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_QUERY, 15, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_READ,  15, $urandom, $urandom);
        queue_item(mcsf_pkg::OP_BURST, 1, $urandom, 4);
        wait_drained();

        // Random phases; pause for all results between them, one phase without idling
        for (int phase = 0; phase < 4; phase++) begin
            idle_on = (phase != 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r  = $urandom_range(0, 99);
                ch = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
                n  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 127);
                spare_op = mcsf_pkg::OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
                if (r < 45)      queue_item(mcsf_pkg::OP_WRITE, ch, $urandom, $urandom);
                else if (r < 60) queue_item(mcsf_pkg::OP_READ,  ch, $urandom, $urandom);
                else if (r < 80) queue_item(mcsf_pkg::OP_BURST, ch, $urandom, n);
                else if (r < 85) queue_item(mcsf_pkg::OP_CLEAR, ch, $urandom, $urandom);
                else if (r < 93) queue_item(mcsf_pkg::OP_QUERY, ch, $urandom, $urandom);
                else queue_item(spare_op, ch, $urandom, $urandom);
            end
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
